// ===== rtl/core/bpdq_pkg.sv =====
package bpdq_pkg;

    localparam int CFG_W = 24;
    localparam int LIMIT_W = 7;
    localparam int INTEG_W = 8;
    localparam int CFG_INDEX_W = 3;

    typedef enum logic [2:0] {
        EV_UNSET = 3'd0,
        EV_UP    = 3'd1,
        EV_DOWN  = 3'd2,
        EV_PRESS = 3'd3,
        EV_REL   = 3'd4,
        EV_SHORT = 3'd5,
        EV_LONG  = 3'd6
    } event_t;

    typedef enum logic [1:0] {
        LVL_UNSET = 2'd0,
        LVL_UP    = 2'd1,
        LVL_DOWN  = 2'd2
    } level_t;

    typedef enum logic [2:0] {
        PH_INIT     = 3'b001,
        PH_RELEASED = 3'b010,
        PH_PRESSED  = 3'b100
    } phase_t;

    localparam logic [CFG_INDEX_W-1:0] CFG_DEBOUNCE_LIMIT = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_MIN      = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SHORT_MAX      = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_LONG_MIN       = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_TIME_CAP       = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] CFG_LED_OFF_TIME   = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] CFG_LED_ON_TIME    = 3'd6;

    localparam logic [LIMIT_W-1:0] RST_DEBOUNCE_LIMIT = 7'd50;
    localparam logic [CFG_W-1:0]   RST_SHORT_MIN      = 24'd10000;
    localparam logic [CFG_W-1:0]   RST_SHORT_MAX      = 24'd100000;
    localparam logic [CFG_W-1:0]   RST_LONG_MIN       = 24'd250000;
    localparam logic [CFG_W-1:0]   RST_TIME_CAP       = 24'd1000000;
    localparam logic [CFG_W-1:0]   RST_LED_OFF_TIME   = 24'd250000;
    localparam logic [CFG_W-1:0]   RST_LED_ON_TIME    = 24'd260000;

    typedef struct packed {
        logic [CFG_W-1:0] short_min;
        logic [CFG_W-1:0] short_max;
        logic [CFG_W-1:0] long_min;
        logic [CFG_W-1:0] time_cap;
        logic [CFG_W-1:0] led_off_time;
        logic [CFG_W-1:0] led_on_time;
    } timing_cfg_t;

    typedef struct packed {
        event_t ev;
        logic   led_write;
        logic   led_level;
    } result_t;

endpackage

// ===== rtl/core/bpdq_debounce.sv =====
module bpdq_debounce
    import bpdq_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               advance,
    input  logic               pin,
    input  logic [LIMIT_W-1:0] limit,
    output level_t             level
);

    logic signed [INTEG_W-1:0] integ_reg;
    logic signed [INTEG_W-1:0] integ_next;
    logic signed [INTEG_W-1:0] lim_pos;
    logic signed [INTEG_W-1:0] lim_neg;

    assign lim_pos = $signed({1'b0, limit});
    assign lim_neg = -lim_pos;

    // Settled only once the integrator already sits at the limit
    always_comb
    begin
        integ_next = integ_reg;
        level      = LVL_UNSET;
        if (pin)
        begin
            if (integ_reg < lim_pos)
                integ_next = integ_reg + 8'sd1;
            else
                level = LVL_UP;
        end
        else
        begin
            if (integ_reg > lim_neg)
                integ_next = integ_reg - 8'sd1;
            else
                level = LVL_DOWN;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            integ_reg <= '0;
        else if (advance)
            integ_reg <= integ_next;
    end

endmodule

// ===== rtl/core/bpdq_tracker.sv =====
module bpdq_tracker
    import bpdq_pkg::*;
#(
    parameter int TIME_WIDTH = 24
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        advance,
    input  level_t      level,
    input  timing_cfg_t cfg,
    output result_t     result
);

    localparam int CMP_W = (TIME_WIDTH > CFG_W) ? TIME_WIDTH : CFG_W;

    phase_t                phase_reg;
    phase_t                phase_next;
    logic [TIME_WIDTH-1:0] time_reg;
    logic [TIME_WIDTH-1:0] time_next;
    logic [TIME_WIDTH-1:0] time_inc;
    logic [CMP_W-1:0]      t_ext;

    // Saturate at the cap and at the counter's own width
    always_comb
    begin
        time_inc = time_reg;
        if ((CMP_W'(time_reg) < CMP_W'(cfg.time_cap)) && (time_reg != '1))
            time_inc = time_reg + 1'b1;
    end

    assign t_ext = CMP_W'(time_inc);

    always_comb
    begin
        phase_next       = phase_reg;
        time_next        = time_reg;
        result.ev        = EV_UNSET;
        result.led_write = 1'b0;
        result.led_level = 1'b0;
        case (phase_reg)
            PH_INIT:
            begin
                if (level == LVL_UP)
                begin
                    result.ev  = EV_UP;
                    phase_next = PH_RELEASED;
                end
                else if (level == LVL_DOWN)
                begin
                    result.ev  = EV_DOWN;
                    time_next  = '0;
                    phase_next = PH_PRESSED;
                end
            end
            PH_RELEASED:
            begin
                result.ev = EV_UP;
                if (level == LVL_DOWN)
                begin
                    result.ev  = EV_PRESS;
                    time_next  = '0;
                    phase_next = PH_PRESSED;
                end
            end
            PH_PRESSED:
            begin
                result.ev = EV_DOWN;
                time_next = time_inc;
                if (t_ext == CMP_W'(cfg.led_off_time))
                begin
                    result.led_write = 1'b1;
                    result.led_level = 1'b0;
                end
                else if (t_ext == CMP_W'(cfg.led_on_time))
                begin
                    result.led_write = 1'b1;
                    result.led_level = 1'b1;
                end
                if (level == LVL_UP)
                begin
                    if ((t_ext > CMP_W'(cfg.short_min)) && (t_ext < CMP_W'(cfg.short_max)))
                        result.ev = EV_SHORT;
                    else if (t_ext >= CMP_W'(cfg.long_min))
                    begin
                        // long release always leaves the LED on
                        result.ev        = EV_LONG;
                        result.led_write = 1'b1;
                        result.led_level = 1'b1;
                    end
                    else
                        result.ev = EV_REL;
                    phase_next = PH_RELEASED;
                end
            end
            default:
            begin
                time_next  = '0;
                phase_next = PH_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_INIT;
            time_reg  <= '0;
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            time_reg  <= time_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_PRESSED && level == LVL_UP) |=> phase_reg == PH_RELEASED)
        else $error("press not ended on settled up");

    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && phase_reg == PH_RELEASED && level == LVL_DOWN) |=> time_reg == '0)
        else $error("press time not cleared at press");

    assert property (@(posedge clk) disable iff (!rst_n)
        (!advance) |=> $stable(time_reg) && $stable(phase_reg))
        else $error("tracker state moved without an item");

endmodule

// ===== rtl/core/button_press_duration_qualifier.sv =====
// Button press qualifier: takes one raw pin sample per item (1 released, 0 pressed), debounces
// it with a saturating up/down integrator and reports one result per sample: the settled
// level, press, and plain/short/long release, plus indicator LED writes at two press times.
// Throughput is one item per clock cycle while result_stall does not hold the result; each item passes
// through the sample register, then through the integrator and tracker logic into the result register.
// The critical path is the press-counter increment followed by the 24-bit threshold compares.
// Write configuration registers only while no item is in flight.
module button_press_duration_qualifier
    import bpdq_pkg::*;
#(
    parameter int TIME_WIDTH = 24
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   sample_valid,
    output logic                   sample_stall,
    input  logic                   pin_level,
    output logic                   result_valid,
    input  logic                   result_stall,
    output logic [2:0]             event_res,
    output logic                   led_write,
    output logic                   led_level,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]       cfg_data
);

    logic [LIMIT_W-1:0] limit_reg;
    timing_cfg_t        cfg_reg;
    logic               s1_valid_reg;
    logic               s1_pin_reg;
    logic               res_valid_reg;
    result_t            res_reg;
    logic               advance;
    level_t             level;
    result_t            res_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg            <= RST_DEBOUNCE_LIMIT;
            cfg_reg.short_min    <= RST_SHORT_MIN;
            cfg_reg.short_max    <= RST_SHORT_MAX;
            cfg_reg.long_min     <= RST_LONG_MIN;
            cfg_reg.time_cap     <= RST_TIME_CAP;
            cfg_reg.led_off_time <= RST_LED_OFF_TIME;
            cfg_reg.led_on_time  <= RST_LED_ON_TIME;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_DEBOUNCE_LIMIT: limit_reg            <= cfg_data[LIMIT_W-1:0];
                CFG_SHORT_MIN:      cfg_reg.short_min    <= cfg_data;
                CFG_SHORT_MAX:      cfg_reg.short_max    <= cfg_data;
                CFG_LONG_MIN:       cfg_reg.long_min     <= cfg_data;
                CFG_TIME_CAP:       cfg_reg.time_cap     <= cfg_data;
                CFG_LED_OFF_TIME:   cfg_reg.led_off_time <= cfg_data;
                CFG_LED_ON_TIME:    cfg_reg.led_on_time  <= cfg_data;
                default:            ;
            endcase
        end
    end

    // Move the held sample on whenever the result register is free or being taken
    assign advance      = s1_valid_reg && (!res_valid_reg || !result_stall);
    assign sample_stall = s1_valid_reg && !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (!sample_stall)
            s1_valid_reg <= sample_valid;
    end

    always_ff @(posedge clk)
    begin
        if (sample_valid && !sample_stall)
            s1_pin_reg <= pin_level;
    end

    bpdq_debounce u_debounce (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .pin     (s1_pin_reg),
        .limit   (limit_reg),
        .level   (level)
    );

    bpdq_tracker #(
        .TIME_WIDTH (TIME_WIDTH)
    ) u_tracker (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .level   (level),
        .cfg     (cfg_reg),
        .result  (res_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (!result_stall)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign event_res    = res_reg.ev;
    assign led_write    = res_reg.led_write;
    assign led_level    = res_reg.led_level;

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && event_res == EV_LONG) |-> (led_write && led_level))
        else $error("long release without LED on");

    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !led_write) |-> !led_level)
        else $error("LED level set without a write");

    assert property (@(posedge clk) disable iff (!rst_n)
        sample_stall |-> (s1_valid_reg && res_valid_reg && result_stall))
        else $error("sample stalled with room downstream");

    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> result_valid)
        else $error("item lost between sample and result register");

endmodule
